[hdl/polled_telemetry_responder_core_defines.svh]
// Assertion macros shared by the responder modules.
`ifndef POLLED_TELEMETRY_RESPONDER_CORE_DEFINES_SVH
`define POLLED_TELEMETRY_RESPONDER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PTR_ASSERT_CR(label, c, r, prop, msg) \
	label: assert property (@(posedge c) disable iff (!r) prop) else $error(msg);
`define PTR_ASSERT(label, prop, msg) \
	`PTR_ASSERT_CR(label, clk, arst_n, prop, msg)
`else
`define PTR_ASSERT_CR(label, c, r, prop, msg)
`define PTR_ASSERT(label, prop, msg)
`endif

`endif

[hdl/ptr_pkg.sv]
`default_nettype none
package ptr_pkg;

	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned SLOT_IDX_W  = 5;
	localparam int unsigned SKIP_W      = 4;
	localparam int unsigned ID_W        = 16;
	localparam int unsigned MASK_W      = 32;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned FRAME_BYTES = 7;
	localparam int unsigned FRAME_W     = FRAME_BYTES * BYTE_W;

	localparam logic [BYTE_W-1:0] START_BYTE = 8'h7E;
	localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h7D;
	localparam logic [BYTE_W-1:0] ESC_START  = 8'h5E;
	localparam logic [BYTE_W-1:0] ESC_ESC    = 8'h5D;
	localparam logic [BYTE_W-1:0] CSUM_BASE  = 8'hFF;
	localparam logic [SKIP_W-1:0] SKIP_MAX   = 4'hF;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_MASK   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_ID       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ID_BASE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_HEADER   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_NODATA_HEADER = 3'd5;

	localparam logic [MASK_W-1:0] ACTIVE_MASK_RST   = 32'hFE00_03FF;
	localparam logic [BYTE_W-1:0] POLL_ID_RST       = 8'h00;
	localparam logic [ID_W-1:0]   ID_BASE_RST       = 16'h5100;
	localparam logic [SKIP_W-1:0] SKIP_LIMIT_RST    = 4'd5;
	localparam logic [BYTE_W-1:0] DATA_HEADER_RST   = 8'h10;
	localparam logic [BYTE_W-1:0] NODATA_HEADER_RST = 8'h00;

	typedef struct packed {
		logic [MASK_W-1:0] active_mask;
		logic [BYTE_W-1:0] poll_id;
		logic [ID_W-1:0]   id_base;
		logic [SKIP_W-1:0] skip_limit;
		logic [BYTE_W-1:0] data_header;
		logic [BYTE_W-1:0] nodata_header;
	} cfg_t;

	typedef struct packed {
		logic                  is_poll;
		logic [SLOT_IDX_W-1:0] slot_index;
		logic [VALUE_W-1:0]    slot_value;
	} cmd_t;

	typedef struct packed {
		logic               valid;
		logic [FRAME_W-1:0] bytes;
	} frame_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_UPD,
		B_SEARCH,
		B_POLL
	} back_state_t;

endpackage
`default_nettype wire

[hdl/ptr_if.sv]
`default_nettype none
interface ptr_in_if;
	logic                            valid;
	logic                            ready;
	logic                            action;
	logic [ptr_pkg::BYTE_W-1:0]      rx_byte;
	logic [ptr_pkg::SLOT_IDX_W-1:0]  slot_index;
	logic [ptr_pkg::VALUE_W-1:0]     slot_value;
	modport source(output valid, action, rx_byte, slot_index, slot_value, input ready);
	modport sink(input valid, action, rx_byte, slot_index, slot_value, output ready);
endinterface

interface ptr_out_if;
	logic                       valid;
	logic                       ready;
	logic [ptr_pkg::BYTE_W-1:0] tx_byte;
	logic                       last_byte;
	modport source(output valid, tx_byte, last_byte, input ready);
	modport sink(input valid, tx_byte, last_byte, output ready);
endinterface

interface ptr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ptr_pkg::CFG_IDX_W-1:0]  index;
	logic [ptr_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/polled_telemetry_responder_core.sv]
`default_nettype none
// Answers polls on a half-duplex sensor bus from a set of value slots.
// The in_ch channel carries one word per received bus byte or per slot
// update; the block parses start and id bytes and queues updates and polls
// in a two-word queue, so in_ch keeps accepting one word per cycle while
// the queue has room. The out_ch channel carries the stuffed answer bytes,
// with last_byte set on the final byte of each frame. The cfg_ch channel
// writes the six configuration registers and is always ready.
// An update reads its slot in the slot engine and writes it only if the
// value differs. An answered poll leaves the queue, then the round-robin
// search examines slots (at most SLOT_COUNT, the slot store read overlaps
// the last one), then the frame goes to the framer, which forms the first
// byte and then the rest, 8 to 16 output bytes. Reset clears the parser,
// the queue, the slot valid and change flags, so all slots read as zero,
// and loads the register defaults; the first poll serves slot zero first.
// When the receiver stalls, the output byte holds, the framer waits, and
// the queue and then in_ch apply backpressure.
module polled_telemetry_responder_core #(
	parameter int SLOT_COUNT = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	ptr_in_if.sink     in_ch,
	ptr_out_if.source  out_ch,
	ptr_cfg_if.sink    cfg_ch
);

	ptr_pkg::cfg_t   cfg_q;
	logic            q_push;
	logic            q_pop;
	logic            q_full;
	logic            q_empty;
	ptr_pkg::cmd_t   q_in;
	ptr_pkg::cmd_t   q_out;
	ptr_pkg::frame_t frm;
	logic            frm_ready;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_mask   <= ptr_pkg::ACTIVE_MASK_RST;
			cfg_q.poll_id       <= ptr_pkg::POLL_ID_RST;
			cfg_q.id_base       <= ptr_pkg::ID_BASE_RST;
			cfg_q.skip_limit    <= ptr_pkg::SKIP_LIMIT_RST;
			cfg_q.data_header   <= ptr_pkg::DATA_HEADER_RST;
			cfg_q.nodata_header <= ptr_pkg::NODATA_HEADER_RST;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				ptr_pkg::CFG_ACTIVE_MASK:   cfg_q.active_mask   <= cfg_ch.data;
				ptr_pkg::CFG_POLL_ID:       cfg_q.poll_id       <= cfg_ch.data[7:0];
				ptr_pkg::CFG_ID_BASE:       cfg_q.id_base       <= cfg_ch.data[15:0];
				ptr_pkg::CFG_SKIP_LIMIT:    cfg_q.skip_limit    <= cfg_ch.data[3:0];
				ptr_pkg::CFG_DATA_HEADER:   cfg_q.data_header   <= cfg_ch.data[7:0];
				ptr_pkg::CFG_NODATA_HEADER: cfg_q.nodata_header <= cfg_ch.data[7:0];
				default: begin
				end
			endcase
		end
	end

	ptr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.poll_id (cfg_q.poll_id),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_in)
	);

	ptr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	ptr_back #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_data    (q_out),
		.frm_ready (frm_ready),
		.frm       (frm)
	);

	ptr_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.frm       (frm),
		.frm_ready (frm_ready),
		.out_ch    (out_ch)
	);

endmodule
`default_nettype wire

[hdl/ptr_front.sv]
`default_nettype none
module ptr_front (
	input  logic                       clk,
	input  logic                       arst_n,
	ptr_in_if.sink                     in_ch,
	input  logic [ptr_pkg::BYTE_W-1:0] poll_id,
	input  logic                       q_full,
	output logic                       q_push,
	output ptr_pkg::cmd_t              q_data
);

	logic expect_q;
	logic expect_d;
	logic acc;

	assign in_ch.ready = !q_full;
	assign acc = in_ch.valid && in_ch.ready;

	always_comb begin
		q_push            = 1'b0;
		expect_d          = expect_q;
		q_data.is_poll    = !in_ch.action;
		q_data.slot_index = in_ch.slot_index;
		q_data.slot_value = in_ch.slot_value;
		if (acc) begin
			priority if (in_ch.action) begin
				q_push = 1'b1;
			end else if (in_ch.rx_byte == ptr_pkg::START_BYTE) begin
				expect_d = 1'b1;
			end else if (expect_q) begin
				expect_d = 1'b0;
				q_push   = (in_ch.rx_byte == poll_id);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q <= 1'b0;
		end else begin
			expect_q <= expect_d;
		end
	end

endmodule
`default_nettype wire

[hdl/ptr_queue.sv]
`default_nettype none
`include "polled_telemetry_responder_core_defines.svh"
module ptr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ptr_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output ptr_pkg::cmd_t pop_data,
	output logic          empty
);

	localparam int PW = $clog2(ptr_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(ptr_pkg::QUEUE_DEPTH + 1);

	ptr_pkg::cmd_t  mem_q [ptr_pkg::QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign full     = (cnt_q == CW'(ptr_pkg::QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`PTR_ASSERT(a_no_overflow, !(push && full && !pop), "Queue written while full.")

endmodule
`default_nettype wire

[hdl/ptr_back.sv]
`default_nettype none
`include "polled_telemetry_responder_core_defines.svh"
module ptr_back #(
	parameter int SLOT_COUNT = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ptr_pkg::cfg_t   cfg,
	input  logic            q_empty,
	output logic            q_pop,
	input  ptr_pkg::cmd_t   q_data,
	input  logic            frm_ready,
	output ptr_pkg::frame_t frm
);

	localparam int SW    = $clog2(SLOT_COUNT);
	localparam int ENT_W = ptr_pkg::SKIP_W + ptr_pkg::VALUE_W;

	logic [ENT_W-1:0]               mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]          vld_q;
	logic [SLOT_COUNT-1:0]          chg_q;
	logic [SLOT_COUNT-1:0]          act;
	logic [ENT_W-1:0]               rd_q;
	logic                           rd_vld_q;

	ptr_pkg::back_state_t           state_q, state_d;
	logic [SW-1:0]                  n_q, n_d;
	logic [SW-1:0]                  tries_q, tries_d;
	logic [SW-1:0]                  last_q, last_d;
	ptr_pkg::cmd_t                  cmd_q, cmd_d;

	logic                           rd_en;
	logic [SW-1:0]                  rd_addr;
	logic                           we;
	logic [SW-1:0]                  wr_addr;
	logic [ENT_W-1:0]               wr_data;
	logic                           chg_set;
	logic                           chg_clr;

	logic [ENT_W-1:0]               cur;
	logic [ptr_pkg::SKIP_W-1:0]     cur_skips;
	logic [ptr_pkg::VALUE_W-1:0]    cur_val;
	logic [ptr_pkg::SKIP_W-1:0]     skips_next;
	logic [SW-1:0]                  upd_addr;
	logic                           upd_in_range;
	logic [SW-1:0]                  cand;
	logic                           send_data;
	logic [ptr_pkg::ID_W-1:0]       slot_id;

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_act
		if (i < ptr_pkg::MASK_W) begin : g_mask
			assign act[i] = cfg.active_mask[i];
		end else begin : g_none
			assign act[i] = 1'b0;
		end
	end

	assign cur          = rd_vld_q ? rd_q : '0;
	assign cur_skips    = cur[ENT_W-1:ptr_pkg::VALUE_W];
	assign cur_val      = cur[ptr_pkg::VALUE_W-1:0];
	assign upd_addr     = SW'(cmd_q.slot_index);
	assign upd_in_range = ({27'd0, cmd_q.slot_index} < 32'(SLOT_COUNT));
	assign cand         = (n_q == SW'(SLOT_COUNT - 1)) ? '0 : n_q + SW'(1);
	assign send_data    = chg_q[n_q] || (cur_skips > cfg.skip_limit);
	assign slot_id      = cfg.id_base + ptr_pkg::ID_W'(n_q);
	assign skips_next   = send_data ? '0 :
		((cur_skips == ptr_pkg::SKIP_MAX) ? ptr_pkg::SKIP_MAX : cur_skips + 4'd1);

	always_comb begin
		state_d   = state_q;
		n_d       = n_q;
		tries_d   = tries_q;
		last_d    = last_q;
		cmd_d     = cmd_q;
		q_pop     = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = n_q;
		we        = 1'b0;
		wr_addr   = n_q;
		wr_data   = {cur_skips, cur_val};
		chg_set   = 1'b0;
		chg_clr   = 1'b0;
		frm.valid = 1'b0;
		frm.bytes = send_data ? {cur_val, slot_id, cfg.data_header}
		                      : {48'd0, cfg.nodata_header};
		unique case (state_q)
			ptr_pkg::B_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					cmd_d = q_data;
					if (q_data.is_poll) begin
						n_d     = last_q;
						tries_d = '0;
						state_d = ptr_pkg::B_SEARCH;
					end else begin
						rd_en   = 1'b1;
						rd_addr = SW'(q_data.slot_index);
						state_d = ptr_pkg::B_UPD;
					end
				end
			end
			ptr_pkg::B_UPD: begin
				state_d = ptr_pkg::B_IDLE;
				if (upd_in_range && (cur_val != cmd_q.slot_value)) begin
					we      = 1'b1;
					wr_addr = upd_addr;
					wr_data = {cur_skips, cmd_q.slot_value};
					chg_set = 1'b1;
				end
			end
			ptr_pkg::B_SEARCH: begin
				n_d = cand;
				if (act[cand]) begin
					rd_en   = 1'b1;
					rd_addr = cand;
					state_d = ptr_pkg::B_POLL;
				end else if (tries_q == SW'(SLOT_COUNT - 1)) begin
					state_d = ptr_pkg::B_IDLE;
				end else begin
					tries_d = tries_q + SW'(1);
				end
			end
			ptr_pkg::B_POLL: begin
				frm.valid = 1'b1;
				if (frm_ready) begin
					we      = 1'b1;
					wr_addr = n_q;
					wr_data = {skips_next, cur_val};
					chg_clr = send_data;
					last_d  = n_q;
					state_d = ptr_pkg::B_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptr_pkg::B_IDLE;
			n_q     <= '0;
			tries_q <= '0;
			last_q  <= SW'(SLOT_COUNT - 1);
			vld_q   <= '0;
			chg_q   <= '0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			tries_q <= tries_d;
			last_q  <= last_d;
			if (we) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (chg_set) begin
				chg_q[wr_addr] <= 1'b1;
			end else if (chg_clr) begin
				chg_q[wr_addr] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q     <= mem[rd_addr];
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	`PTR_ASSERT(a_write_state, we |-> (state_q == ptr_pkg::B_UPD || state_q == ptr_pkg::B_POLL), "Slot store written outside an update or poll.")
	`PTR_ASSERT(a_poll_active, state_q == ptr_pkg::B_POLL |-> act[n_q], "Poll answer picked an inactive slot.")

endmodule
`default_nettype wire

[hdl/ptr_framer.sv]
`default_nettype none
`include "polled_telemetry_responder_core_defines.svh"
module ptr_framer (
	input  logic            clk,
	input  logic            arst_n,
	input  ptr_pkg::frame_t frm,
	output logic            frm_ready,
	ptr_out_if.source       out_ch
);

	logic                        busy_q, busy_d;
	logic                        pend_q, pend_d;
	logic                        out_v_q, out_v_d;
	logic [ptr_pkg::FRAME_W-1:0] sh_q, sh_d;
	logic [2:0]                  idx_q, idx_d;
	logic [ptr_pkg::BYTE_W-1:0]  sum_q, sum_d;
	logic [ptr_pkg::BYTE_W-1:0]  pend_byte_q, pend_byte_d;
	logic                        pend_last_q, pend_last_d;
	logic [ptr_pkg::BYTE_W-1:0]  tx_q, tx_d;
	logic                        last_q, last_d;

	logic                        adv;
	logic                        is_last;
	logic [ptr_pkg::BYTE_W-1:0]  cur;
	logic [ptr_pkg::BYTE_W:0]    sum_t;
	logic [ptr_pkg::BYTE_W-1:0]  sum_n;
	logic                        needs_esc;

	assign frm_ready        = !busy_q;
	assign out_ch.valid     = out_v_q;
	assign out_ch.tx_byte   = tx_q;
	assign out_ch.last_byte = last_q;

	assign adv       = busy_q && (!out_v_q || out_ch.ready);
	assign is_last   = (idx_q == 3'd7);
	assign cur       = is_last ? (ptr_pkg::CSUM_BASE - sum_q) : sh_q[ptr_pkg::BYTE_W-1:0];
	assign sum_t     = {1'b0, sum_q} + {1'b0, cur};
	assign sum_n     = sum_t[ptr_pkg::BYTE_W-1:0] + {7'd0, sum_t[ptr_pkg::BYTE_W]};
	assign needs_esc = (cur == ptr_pkg::START_BYTE) || (cur == ptr_pkg::ESC_BYTE);

	always_comb begin
		busy_d      = busy_q;
		pend_d      = pend_q;
		out_v_d     = out_v_q && !out_ch.ready;
		sh_d        = sh_q;
		idx_d       = idx_q;
		sum_d       = sum_q;
		pend_byte_d = pend_byte_q;
		pend_last_d = pend_last_q;
		tx_d        = tx_q;
		last_d      = last_q;
		priority if (!busy_q && frm.valid) begin
			busy_d = 1'b1;
			pend_d = 1'b0;
			sh_d   = frm.bytes;
			idx_d  = '0;
			sum_d  = '0;
		end else if (adv) begin
			out_v_d = 1'b1;
			if (pend_q) begin
				tx_d   = pend_byte_q;
				last_d = pend_last_q;
				pend_d = 1'b0;
				busy_d = !pend_last_q;
			end else begin
				sum_d = sum_n;
				sh_d  = sh_q >> ptr_pkg::BYTE_W;
				idx_d = idx_q + 3'd1;
				if (needs_esc) begin
					tx_d        = ptr_pkg::ESC_BYTE;
					last_d      = 1'b0;
					pend_d      = 1'b1;
					pend_byte_d = (cur == ptr_pkg::START_BYTE) ? ptr_pkg::ESC_START
					                                           : ptr_pkg::ESC_ESC;
					pend_last_d = is_last;
				end else begin
					tx_d   = cur;
					last_d = is_last;
					busy_d = !is_last;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pend_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			busy_q  <= busy_d;
			pend_q  <= pend_d;
			out_v_q <= out_v_d;
		end
	end

	always_ff @(posedge clk) begin
		sh_q        <= sh_d;
		idx_q       <= idx_d;
		sum_q       <= sum_d;
		pend_byte_q <= pend_byte_d;
		pend_last_q <= pend_last_d;
		tx_q        <= tx_d;
		last_q      <= last_d;
	end

	`PTR_ASSERT(a_esc_follow, out_v_q && out_ch.ready && tx_q == ptr_pkg::ESC_BYTE |=> out_v_q && (tx_q == ptr_pkg::ESC_START || tx_q == ptr_pkg::ESC_ESC), "Escape byte not followed by its code.")
	`PTR_ASSERT(a_esc_not_last, out_v_q && tx_q == ptr_pkg::ESC_BYTE |-> !last_q, "Frame ends on an escape byte.")

endmodule
`default_nettype wire

[tb/tb_polled_telemetry_responder_core.sv]
`default_nettype none
module tb_polled_telemetry_responder_core;
	timeunit 1ns;
	timeprecision 1ps;

	import ptr_pkg::*;

	localparam int SLOTS         = 32;
	localparam int SETTLE_CYCLES = 2 * SLOTS + 32;
	localparam int STALL_LIMIT   = 4000;
	localparam int REPORT_LIMIT  = 10;

	localparam logic ACT_RX     = 1'b0;
	localparam logic ACT_UPDATE = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] tx_byte;
		logic              last_byte;
	} tx_word_t;

	logic clk;
	logic arst_n;

	ptr_in_if  in_ch();
	ptr_out_if out_ch();
	ptr_cfg_if cfg_ch();

	polled_telemetry_responder_core #(
		.SLOT_COUNT(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	logic [MASK_W-1:0]  cfg_mask;
	logic [BYTE_W-1:0]  cfg_poll_id;
	logic [ID_W-1:0]    cfg_id_base;
	logic [SKIP_W-1:0]  cfg_skip_limit;
	logic [BYTE_W-1:0]  cfg_data_hdr;
	logic [BYTE_W-1:0]  cfg_nodata_hdr;

	logic               awaiting_id;
	int                 prev_slot;
	logic [VALUE_W-1:0] slot_val [SLOTS];
	logic               slot_dirty [SLOTS];
	logic [SKIP_W-1:0]  slot_skip [SLOTS];

	tx_word_t answer_bytes [$];

	int  mismatches;
	int  words_sent;
	int  bytes_checked;
	int  data_frames;
	int  nodata_frames;
	int  reg_writes;
	int  hold_request;
	bit  src_steady;
	bit  snk_steady;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int stall_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int source_gap();
		if (src_steady || $urandom_range(0, 99) < 60)
			return 0;
		return stall_length();
	endfunction

	function automatic logic slot_is_active(input int n);
		return n < 32 && n < SLOTS && cfg_mask[n];
	endfunction

	task automatic push_stuffed(input logic [BYTE_W-1:0] b, input logic is_last);
		tx_word_t w;
		w.last_byte = 1'b0;
		if (b == START_BYTE || b == ESC_BYTE) begin
			w.tx_byte = ESC_BYTE;
			answer_bytes.push_back(w);
			w.tx_byte = (b == START_BYTE) ? ESC_START : ESC_ESC;
		end else begin
			w.tx_byte = b;
		end
		w.last_byte = is_last;
		answer_bytes.push_back(w);
	endtask

	task automatic predict_poll_answer();
		int                 n;
		int                 tries;
		int unsigned        sum;
		logic [ID_W-1:0]    vid;
		logic [BYTE_W-1:0]  frame [8];
		n = prev_slot;
		for (tries = 0; tries < SLOTS; tries++) begin
			n = (n + 1 >= SLOTS) ? 0 : n + 1;
			if (slot_is_active(n))
				break;
		end
		if (!slot_is_active(n))
			return;
		if (slot_dirty[n] || slot_skip[n] > cfg_skip_limit) begin
			vid = cfg_id_base + ID_W'(n);
			frame[0] = cfg_data_hdr;
			frame[1] = vid[7:0];
			frame[2] = vid[15:8];
			for (int i = 0; i < 4; i++)
				frame[3 + i] = slot_val[n][i*8 +: 8];
			slot_dirty[n] = 1'b0;
			slot_skip[n] = '0;
			data_frames++;
		end else begin
			frame[0] = cfg_nodata_hdr;
			for (int i = 1; i < 7; i++)
				frame[i] = '0;
			if (slot_skip[n] != SKIP_MAX)
				slot_skip[n] = slot_skip[n] + 1'b1;
			nodata_frames++;
		end
		sum = 0;
		for (int i = 0; i < 7; i++) begin
			sum = sum + frame[i];
			sum = sum + (sum >> 8);
			sum = sum & 32'hFF;
		end
		frame[7] = CSUM_BASE - sum[7:0];
		for (int i = 0; i < 8; i++)
			push_stuffed(frame[i], i == 7);
		prev_slot = n;
	endtask

	task automatic predict_answer(input logic act, input logic [BYTE_W-1:0] rx,
			input logic [SLOT_IDX_W-1:0] idx, input logic [VALUE_W-1:0] val);
		if (act == ACT_UPDATE) begin
			if (int'(idx) < SLOTS && slot_val[idx] != val) begin
				slot_val[idx] = val;
				slot_dirty[idx] = 1'b1;
			end
			return;
		end
		if (rx == START_BYTE) begin
			awaiting_id = 1'b1;
			return;
		end
		if (!awaiting_id)
			return;
		awaiting_id = 1'b0;
		if (rx == cfg_poll_id)
			predict_poll_answer();
	endtask

	task automatic send_word(input logic act, input logic [BYTE_W-1:0] rx,
			input logic [SLOT_IDX_W-1:0] idx, input logic [VALUE_W-1:0] val);
		int gap;
		gap = source_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.action     <= act;
		in_ch.rx_byte    <= rx;
		in_ch.slot_index <= idx;
		in_ch.slot_value <= val;
		do @(posedge clk); while (!in_ch.ready);
		predict_answer(act, rx, idx, val);
		words_sent++;
	endtask

	task automatic send_rx(input logic [BYTE_W-1:0] b);
		send_word(ACT_RX, b, SLOT_IDX_W'($urandom), $urandom);
	endtask

	task automatic send_update(input logic [SLOT_IDX_W-1:0] idx, input logic [VALUE_W-1:0] val);
		send_word(ACT_UPDATE, BYTE_W'($urandom), idx, val);
	endtask

	task automatic send_poll(input logic [BYTE_W-1:0] id);
		send_rx(START_BYTE);
		send_rx(id);
	endtask

	task automatic wait_answers_drained();
		while (answer_bytes.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		if (in_ch.valid) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		wait_answers_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_ACTIVE_MASK:   cfg_mask       = data[MASK_W-1:0];
			CFG_POLL_ID:       cfg_poll_id    = data[BYTE_W-1:0];
			CFG_ID_BASE:       cfg_id_base    = data[ID_W-1:0];
			CFG_SKIP_LIMIT:    cfg_skip_limit = data[SKIP_W-1:0];
			CFG_DATA_HEADER:   cfg_data_hdr   = data[BYTE_W-1:0];
			CFG_NODATA_HEADER: cfg_nodata_hdr = data[BYTE_W-1:0];
			default: ;
		endcase
		reg_writes++;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [MASK_W-1:0] mask, input logic [BYTE_W-1:0] pid,
			input logic [ID_W-1:0] base, input logic [SKIP_W-1:0] lim,
			input logic [BYTE_W-1:0] dhdr, input logic [BYTE_W-1:0] nhdr);
		settle();
		write_reg(CFG_ACTIVE_MASK, CFG_DATA_W'(mask));
		write_reg(CFG_POLL_ID, CFG_DATA_W'(pid));
		write_reg(CFG_ID_BASE, CFG_DATA_W'(base));
		write_reg(CFG_SKIP_LIMIT, CFG_DATA_W'(lim));
		write_reg(CFG_DATA_HEADER, CFG_DATA_W'(dhdr));
		write_reg(CFG_NODATA_HEADER, CFG_DATA_W'(nhdr));
	endtask

	task automatic check_tx_word(input logic [BYTE_W-1:0] b, input logic is_last);
		tx_word_t want;
		if (answer_bytes.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("[%0t] Unexpected byte %02h last_byte %0b", $realtime, b, is_last);
			return;
		end
		want = answer_bytes.pop_front();
		if (want.tx_byte !== b || want.last_byte !== is_last) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("[%0t] Byte %0d: expected %02h last_byte %0b, got %02h last_byte %0b",
					$realtime, bytes_checked, want.tx_byte, want.last_byte, b, is_last);
		end
		bytes_checked++;
	endtask

	initial begin : result_sink
		int stall;
		int hold;
		stall = 0;
		hold = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready)
				check_tx_word(out_ch.tx_byte, out_ch.last_byte);
			if (hold_request > 0) begin
				hold = hold_request;
				hold_request = 0;
			end
			if (hold > 0) begin
				hold--;
				out_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				out_ch.ready <= 1'b0;
			end else if (!snk_steady && $urandom_range(0, 99) < 20) begin
				stall = stall_length() - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready) || !arst_n)
				idle = 0;
			else
				idle++;
		end
		$display("Timeout: no word moved for %0d cycles, %0d bytes still expected",
			idle, answer_bytes.size());
		$display("Test completed with failures");
		$finish;
	end

	// Slot 1 gets a value that needs stuffing, slot 31 all ones, and slot 0 its reset value.
	task automatic test_directed_polls();
		send_update(5'd1, 32'h7D7E_7D7E);
		send_update(5'd31, 32'hFFFF_FFFF);
		send_update(5'd0, 32'h0000_0000);
		send_poll(8'h00);
		send_poll(8'h00);
		send_rx(8'h00);
		send_rx(START_BYTE);
		send_poll(8'h00);
		send_poll(8'h55);
		send_update(5'd1, 32'h7D7E_7D7E);
		send_update(5'd3, 32'h0000_0001);
		send_poll(8'h00);
		send_poll(8'h00);
	endtask

	task automatic test_register_extremes();
		set_config(32'h0000_0000, 8'hFF, 16'hFFE0, 4'd0, 8'h7E, 8'h7D);
		send_poll(8'hFF);
		send_poll(8'hFF);
		set_config(32'hFFFF_FFFF, START_BYTE, 16'h0000, 4'd0, 8'h7E, 8'h7D);
		send_rx(START_BYTE);
		send_rx(START_BYTE);
		send_rx(START_BYTE);
		set_config(32'h8000_0003, ESC_BYTE, 16'h7E7D, 4'd0, 8'hFF, 8'h00);
		send_update(5'd0, 32'h1234_7E7D);
		repeat (4) send_poll(ESC_BYTE);
		set_config(32'hFFFF_FFFF, 8'h00, 16'h0000, 4'd14, 8'h00, 8'hFF);
		repeat (2) send_poll(8'h00);
	endtask

	task automatic test_skip_saturation();
		set_config(32'h0000_0020, 8'h3C, 16'hFFE0, 4'd15, 8'h7D, 8'h7E);
		repeat (17) send_poll(8'h3C);
		set_config(32'h0000_0020, 8'h3C, 16'hFFE0, 4'd14, 8'h7D, 8'h7E);
		send_poll(8'h3C);
		send_poll(8'h3C);
	endtask

	task automatic test_backpressure();
		set_config(32'hFFFF_FFFF, 8'h42, 16'h5100, 4'd3, 8'h10, 8'h00);
		src_steady = 1'b1;
		hold_request = 300;
		for (int i = 0; i < 8; i++) begin
			send_update(SLOT_IDX_W'($urandom), $urandom);
			send_poll(8'h42);
		end
		src_steady = 1'b0;
		settle();
	endtask

	task automatic test_random_traffic();
		int                  count;
		int                  r;
		bit                  paused;
		logic [MASK_W-1:0]   mask;
		logic [BYTE_W-1:0]   pid;
		logic [SLOT_IDX_W-1:0] idx;
		logic [VALUE_W-1:0]  val;
		for (int phase = 0; phase < 4; phase++) begin
			case ($urandom_range(0, 3))
				0: mask = $urandom;
				1: mask = MASK_W'(1) << $urandom_range(0, 31);
				2: mask = '1;
				default: mask = $urandom & $urandom;
			endcase
			do pid = BYTE_W'($urandom_range(0, 255)); while (pid == START_BYTE);
			set_config(mask, pid, ID_W'($urandom_range(0, 65504)),
				SKIP_W'($urandom_range(0, 15)), BYTE_W'($urandom), BYTE_W'($urandom));
			src_steady = (phase == 1);
			snk_steady = (phase == 2);
			count = 0;
			paused = 1'b0;
			while (count < 16) begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					send_poll(cfg_poll_id);
					count += 2;
				end else if (r < 78) begin
					idx = SLOT_IDX_W'($urandom_range(0, 31));
					case ($urandom_range(0, 3))
						0: val = $urandom;
						1: for (int b = 0; b < 4; b++)
							case ($urandom_range(0, 2))
								0: val[b*8 +: 8] = START_BYTE;
								1: val[b*8 +: 8] = ESC_BYTE;
								default: val[b*8 +: 8] = BYTE_W'($urandom);
							endcase
						2: val = slot_val[idx];
						default: val = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
					endcase
					send_update(idx, val);
					count++;
				end else if (r < 90) begin
					send_rx(START_BYTE);
					send_rx(BYTE_W'($urandom_range(0, 255)));
				end else begin
					send_rx(BYTE_W'($urandom_range(0, 255)));
				end
				if (!paused && count >= 8) begin
					paused = 1'b1;
					if (in_ch.valid) begin
						in_ch.valid <= 1'b0;
						@(posedge clk);
					end
					wait_answers_drained();
				end
			end
		end
		src_steady = 1'b0;
		snk_steady = 1'b0;
	endtask

	initial begin : test_sequence
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.action      = ACT_RX;
		in_ch.rx_byte     = '0;
		in_ch.slot_index  = '0;
		in_ch.slot_value  = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = CFG_ACTIVE_MASK;
		cfg_ch.data       = '0;
		hold_request      = 0;
		src_steady        = 1'b0;
		snk_steady        = 1'b0;
		mismatches        = 0;
		words_sent        = 0;
		bytes_checked     = 0;
		data_frames       = 0;
		nodata_frames     = 0;
		reg_writes        = 0;
		cfg_mask          = ACTIVE_MASK_RST;
		cfg_poll_id       = POLL_ID_RST;
		cfg_id_base       = ID_BASE_RST;
		cfg_skip_limit    = SKIP_LIMIT_RST;
		cfg_data_hdr      = DATA_HEADER_RST;
		cfg_nodata_hdr    = NODATA_HEADER_RST;
		awaiting_id       = 1'b0;
		prev_slot         = SLOTS - 1;
		for (int i = 0; i < SLOTS; i++) begin
			slot_val[i]   = '0;
			slot_dirty[i] = 1'b0;
			slot_skip[i]  = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_polls();
		test_register_extremes();
		test_skip_saturation();
		test_backpressure();
		test_random_traffic();
		settle();

		if (answer_bytes.size() != 0)
			mismatches++;
		$display("Sent %0d words; checked %0d bytes from %0d data and %0d no-data frames.",
			words_sent, bytes_checked, data_frames, nodata_frames);
		$display("Made %0d register writes, with receiver hold-off and random gaps; %0d mismatches.",
			reg_writes, mismatches);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
